>>> sv/tsl_pkg.sv
// tsl_pkg: shared sizes, pointer types and sequencer states for the
// topological sort block. no dependencies.
`default_nettype none

package tsl_pkg;

  localparam int MAX_NODES  = 64;
  localparam int MAX_EDGES  = 1024;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int EDGE_AW    = $clog2(MAX_EDGES);
  localparam int EDGE_W     = $clog2(MAX_EDGES + 1);
  localparam int EDGE_RAM_W = NODE_W + EDGE_W;
  localparam int LEVEL_W    = 6;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [EDGE_W-1:0]  eptr_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam eptr_t EDGE_NONE = eptr_t'(MAX_EDGES);

  typedef enum logic [3:0] {
    S_IDLE, S_LINK,
    S_DH, S_DH2, S_DE, S_DI,
    S_EQ, S_EQ2,
    S_POP, S_PX, S_PH, S_PE, S_PI,
    S_OR, S_OV, S_OW
  } state_e;

endpackage

`default_nettype wire

>>> sv/tsl_ram.sv
// tsl_ram: generic single write port, single read port ram with registered read.
// no dependencies.
`default_nettype none

module tsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/topological_sort_levels.sv
// topological_sort_levels: edge loading, kahn sort with longest-path levels, result stream.
// depends on tsl_pkg and tsl_ram.
// load: input is not ready while an edge item is linked into its list; empty items
// are skipped. sort: an in-degree pass over every node's edge list, a pass that seeds
// the queue with the zero in-degree nodes, and a queue pass over each dequeued node's edges.
// results: each is read, registered and held until taken. reset: async low, clears control
// and the valid bits; the graph returns to empty after the last result transfer.
`default_nettype none

module topological_sort_levels (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,     // node_count
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // from_node[5:0], to_node[11:6], zero
  input  wire logic        s_axis_tuser_i,  // edge_valid
  input  wire logic        s_axis_tlast_i,  // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // node[5:0], level[11:6], zero
  output logic [1:0]       m_axis_tuser_o,  // cycle_found[0], edges_dropped[1]
  output logic             m_axis_tlast_o   // last_result
);

  tsl_pkg::state_e state_q, state_d;
  tsl_pkg::cnt_t   node_count_q, n_eff;
  tsl_pkg::cnt_t   i_q, i_d, hp_q, hp_d, tail_q, tail_d;
  tsl_pkg::node_t  a_q, a_d, b_q, b_d, x_q, x_d, t_q, t_d;
  tsl_pkg::eptr_t  ec_q, ec_d, nxt_q, nxt_d;
  tsl_pkg::level_t lvx_q, lvx_d;
  logic            last_q, last_d, ovf_q, ovf_d;
  logic [tsl_pkg::MAX_NODES-1:0] head_vld_q, head_vld_d, deg_vld_q, deg_vld_d;
  logic [tsl_pkg::MAX_NODES-1:0] lvl_vld_q, lvl_vld_d;

  tsl_pkg::node_t  out_node_q, out_node_d;
  tsl_pkg::level_t out_level_q, out_level_d;
  logic            out_cyc_q, out_cyc_d, out_ovf_q, out_ovf_d, out_last_q, out_last_d;

  // ram ports
  logic                           edge_we, head_we, deg_we, lvl_we, q_we;
  logic [tsl_pkg::EDGE_AW-1:0]    edge_waddr, edge_raddr;
  logic [tsl_pkg::EDGE_RAM_W-1:0] edge_wdata, edge_rdata;
  tsl_pkg::node_t                 head_waddr, head_raddr, deg_waddr, deg_raddr;
  tsl_pkg::node_t                 lvl_waddr, lvl_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  tsl_pkg::eptr_t                 head_wdata, head_rdata;
  tsl_pkg::eptr_t                 deg_wdata, deg_rdata;
  tsl_pkg::level_t                lvl_wdata, lvl_rdata;

  logic            in_xfer, i_last, e_in, e_nxt_none, nxt_none, p_none;
  tsl_pkg::node_t  e_t, deg_idx, head_idx;
  tsl_pkg::eptr_t  e_nxt, head_p, deg_val;
  tsl_pkg::cnt_t   i_next;

  tsl_ram #(.WIDTH(tsl_pkg::EDGE_RAM_W), .DEPTH(tsl_pkg::MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata));
  tsl_ram #(.WIDTH(tsl_pkg::EDGE_W), .DEPTH(tsl_pkg::MAX_NODES)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata));
  tsl_ram #(.WIDTH(tsl_pkg::EDGE_W), .DEPTH(tsl_pkg::MAX_NODES)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata));
  tsl_ram #(.WIDTH(tsl_pkg::LEVEL_W), .DEPTH(tsl_pkg::MAX_NODES)) u_lvl_ram (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(lvl_wdata),
    .raddr_i(lvl_raddr), .rdata_o(lvl_rdata));
  tsl_ram #(.WIDTH(tsl_pkg::NODE_W), .DEPTH(tsl_pkg::MAX_NODES)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata));

  // shared decode
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = tsl_pkg::cnt_t'(1);
    end else if (node_count_q > tsl_pkg::cnt_t'(tsl_pkg::MAX_NODES)) begin
      n_eff = tsl_pkg::cnt_t'(tsl_pkg::MAX_NODES);
    end else begin
      n_eff = node_count_q;
    end
    in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
    i_next     = i_q + tsl_pkg::cnt_t'(1);
    i_last     = (i_next == n_eff);
    e_t        = edge_rdata[tsl_pkg::NODE_W-1:0];
    e_nxt      = edge_rdata[tsl_pkg::EDGE_RAM_W-1:tsl_pkg::NODE_W];
    e_in       = ({1'b0, e_t} < n_eff);
    e_nxt_none = (e_nxt >= tsl_pkg::EDGE_NONE);
    nxt_none   = (nxt_q >= tsl_pkg::EDGE_NONE);
    case (state_q)
      tsl_pkg::S_LINK: head_idx = a_q;
      tsl_pkg::S_PH:   head_idx = x_q;
      default:         head_idx = i_q[tsl_pkg::NODE_W-1:0];
    endcase
    head_p  = head_vld_q[head_idx] ? head_rdata : tsl_pkg::EDGE_NONE;
    p_none  = (head_p >= tsl_pkg::EDGE_NONE);
    deg_idx = (state_q == tsl_pkg::S_EQ2) ? i_q[tsl_pkg::NODE_W-1:0] : t_q;
    deg_val = deg_vld_q[deg_idx] ? deg_rdata : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsl_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser_i) state_d = tsl_pkg::S_LINK;
          else if (s_axis_tlast_i) state_d = tsl_pkg::S_DH;
        end
      end
      tsl_pkg::S_LINK: state_d = last_q ? tsl_pkg::S_DH : tsl_pkg::S_IDLE;
      tsl_pkg::S_DH:   state_d = tsl_pkg::S_DH2;
      tsl_pkg::S_DH2: begin
        if (!p_none) state_d = tsl_pkg::S_DE;
        else state_d = i_last ? tsl_pkg::S_EQ : tsl_pkg::S_DH;
      end
      tsl_pkg::S_DE: begin
        if (e_in) state_d = tsl_pkg::S_DI;
        else if (e_nxt_none) state_d = i_last ? tsl_pkg::S_EQ : tsl_pkg::S_DH;
      end
      tsl_pkg::S_DI: begin
        if (!nxt_none) state_d = tsl_pkg::S_DE;
        else state_d = i_last ? tsl_pkg::S_EQ : tsl_pkg::S_DH;
      end
      tsl_pkg::S_EQ:  state_d = tsl_pkg::S_EQ2;
      tsl_pkg::S_EQ2: state_d = i_last ? tsl_pkg::S_POP : tsl_pkg::S_EQ;
      tsl_pkg::S_POP: state_d = (hp_q < tail_q) ? tsl_pkg::S_PX : tsl_pkg::S_OR;
      tsl_pkg::S_PX:  state_d = tsl_pkg::S_PH;
      tsl_pkg::S_PH:  state_d = p_none ? tsl_pkg::S_POP : tsl_pkg::S_PE;
      tsl_pkg::S_PE: begin
        if (e_in) state_d = tsl_pkg::S_PI;
        else if (e_nxt_none) state_d = tsl_pkg::S_POP;
      end
      tsl_pkg::S_PI: state_d = nxt_none ? tsl_pkg::S_POP : tsl_pkg::S_PE;
      tsl_pkg::S_OR: state_d = tsl_pkg::S_OV;
      tsl_pkg::S_OV: state_d = tsl_pkg::S_OW;
      tsl_pkg::S_OW: begin
        if (m_axis_tready_i) state_d = out_last_q ? tsl_pkg::S_IDLE : tsl_pkg::S_OR;
      end
      default: state_d = tsl_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    s_axis_tready_o = (state_q == tsl_pkg::S_IDLE);
    m_axis_tvalid_o = (state_q == tsl_pkg::S_OW);
    i_d = i_q; hp_d = hp_q; tail_d = tail_q;
    a_d = a_q; b_d = b_q; x_d = x_q; t_d = t_q;
    ec_d = ec_q; nxt_d = nxt_q; lvx_d = lvx_q; last_d = last_q; ovf_d = ovf_q;
    head_vld_d = head_vld_q; deg_vld_d = deg_vld_q; lvl_vld_d = lvl_vld_q;
    out_node_d = out_node_q; out_level_d = out_level_q; out_cyc_d = out_cyc_q;
    out_ovf_d = out_ovf_q; out_last_d = out_last_q;
    edge_we = 1'b0; edge_waddr = ec_q[tsl_pkg::EDGE_AW-1:0];
    edge_wdata = {head_p, b_q}; edge_raddr = '0;
    head_we = 1'b0; head_waddr = a_q; head_wdata = ec_q; head_raddr = '0;
    deg_we = 1'b0; deg_waddr = t_q; deg_wdata = deg_val + tsl_pkg::eptr_t'(1);
    deg_raddr = '0;
    lvl_we = 1'b0; lvl_waddr = t_q;
    lvl_wdata = (&lvx_q) ? lvx_q : lvx_q + tsl_pkg::level_t'(1);
    lvl_raddr = '0;
    q_we = 1'b0; q_waddr = tail_q[tsl_pkg::NODE_W-1:0]; q_wdata = t_q;
    q_raddr = hp_q[tsl_pkg::NODE_W-1:0];
    case (state_q)
      tsl_pkg::S_IDLE: begin
        a_d        = s_axis_tdata_i[5:0];
        b_d        = s_axis_tdata_i[11:6];
        last_d     = s_axis_tlast_i;
        head_raddr = s_axis_tdata_i[5:0];
        i_d        = '0;
      end
      tsl_pkg::S_LINK: begin
        if (ec_q >= tsl_pkg::EDGE_NONE) begin
          ovf_d = 1'b1;
        end else begin
          edge_we         = 1'b1;
          head_we         = 1'b1;
          head_vld_d[a_q] = 1'b1;
          ec_d            = ec_q + tsl_pkg::eptr_t'(1);
        end
      end
      tsl_pkg::S_DH: head_raddr = i_q[tsl_pkg::NODE_W-1:0];
      tsl_pkg::S_DH2: begin
        if (!p_none) edge_raddr = head_p[tsl_pkg::EDGE_AW-1:0];
        else i_d = i_last ? '0 : i_next;
      end
      tsl_pkg::S_DE, tsl_pkg::S_PE: begin
        if (e_in) begin
          deg_raddr = e_t;
          t_d       = e_t;
          nxt_d     = e_nxt;
        end else if (!e_nxt_none) begin
          edge_raddr = e_nxt[tsl_pkg::EDGE_AW-1:0];
        end else if (state_q == tsl_pkg::S_DE) begin
          i_d = i_last ? '0 : i_next;
        end
      end
      tsl_pkg::S_DI: begin
        deg_we         = 1'b1;
        deg_vld_d[t_q] = 1'b1;
        if (!nxt_none) edge_raddr = nxt_q[tsl_pkg::EDGE_AW-1:0];
        else i_d = i_last ? '0 : i_next;
      end
      tsl_pkg::S_EQ: deg_raddr = i_q[tsl_pkg::NODE_W-1:0];
      tsl_pkg::S_EQ2: begin
        if (deg_val == '0) begin
          q_we    = 1'b1;
          q_wdata = i_q[tsl_pkg::NODE_W-1:0];
          tail_d  = tail_q + tsl_pkg::cnt_t'(1);
        end
        i_d = i_last ? '0 : i_next;
      end
      tsl_pkg::S_POP: begin
        // hp doubles as the dequeued count
        if (hp_q < tail_q) hp_d = hp_q + tsl_pkg::cnt_t'(1);
        else i_d = '0;
      end
      tsl_pkg::S_PX: begin
        x_d        = q_rdata;
        head_raddr = q_rdata;
        lvl_raddr  = q_rdata;
      end
      tsl_pkg::S_PH: begin
        lvx_d = lvl_vld_q[x_q] ? lvl_rdata : '0;
        if (!p_none) edge_raddr = head_p[tsl_pkg::EDGE_AW-1:0];
      end
      tsl_pkg::S_PI: begin
        if (deg_val != '0) begin
          deg_we    = 1'b1;
          deg_wdata = deg_val - tsl_pkg::eptr_t'(1);
          if (deg_val == tsl_pkg::eptr_t'(1)) begin
            lvl_we         = 1'b1;
            lvl_vld_d[t_q] = 1'b1;
            q_we           = 1'b1;
            tail_d         = tail_q + tsl_pkg::cnt_t'(1);
          end
        end
        if (!nxt_none) edge_raddr = nxt_q[tsl_pkg::EDGE_AW-1:0];
      end
      tsl_pkg::S_OR: lvl_raddr = i_q[tsl_pkg::NODE_W-1:0];
      tsl_pkg::S_OV: begin
        out_node_d  = i_q[tsl_pkg::NODE_W-1:0];
        out_level_d = lvl_vld_q[i_q[tsl_pkg::NODE_W-1:0]] ? lvl_rdata : '0;
        out_cyc_d   = (hp_q < n_eff);
        out_ovf_d   = ovf_q;
        out_last_d  = i_last;
      end
      tsl_pkg::S_OW: begin
        if (m_axis_tready_i) begin
          if (out_last_q) begin
            // graph back to empty for the next batch
            head_vld_d = '0; deg_vld_d = '0; lvl_vld_d = '0;
            ec_d = '0; ovf_d = 1'b0; hp_d = '0; tail_d = '0; i_d = '0;
          end else begin
            i_d = i_next;
          end
        end
      end
      default: ;
    endcase
    m_axis_tdata_o = {4'b0, out_level_q, out_node_q};
    m_axis_tuser_o = {out_ovf_q, out_cyc_q};
    m_axis_tlast_o = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsl_pkg::S_IDLE;
      node_count_q <= tsl_pkg::cnt_t'(tsl_pkg::MAX_NODES);
      i_q <= '0; hp_q <= '0; tail_q <= '0; ec_q <= '0;
      ovf_q <= 1'b0; last_q <= 1'b0;
      head_vld_q <= '0; deg_vld_q <= '0; lvl_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      i_q <= i_d; hp_q <= hp_d; tail_q <= tail_d; ec_q <= ec_d;
      ovf_q <= ovf_d; last_q <= last_d;
      head_vld_q <= head_vld_d; deg_vld_q <= deg_vld_d; lvl_vld_q <= lvl_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; x_q <= x_d; t_q <= t_d;
    nxt_q <= nxt_d; lvx_q <= lvx_d;
    out_node_q <= out_node_d; out_level_q <= out_level_d;
    out_cyc_q <= out_cyc_d; out_ovf_q <= out_ovf_d; out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

>>> sv/tsl_checker.sv
// tsl_checker: port-level checks for topological_sort_levels, bound to the top level.
// no dependencies beyond the top level's ports.
`default_nettype none

module tsl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // input is never taken while results are pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready during result phase");

  // the final result closes the batch
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("batch not closed after final result");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:12] == 4'b0)
    else $error("result padding not zero");

endmodule

bind topological_sort_levels tsl_checker u_tsl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o));

`default_nettype wire
